### rtl/utf8cp_pkg.sv
// Shared types and constants for the UTF-8 to CP437 transcoder.
package utf8cp_pkg;

    localparam int unsigned ACC_W = 21;

    // Sequence lengths
    localparam logic [2:0] SEQ_LEN_1 = 3'd1;
    localparam logic [2:0] SEQ_LEN_2 = 3'd2;
    localparam logic [2:0] SEQ_LEN_3 = 3'd3;
    localparam logic [2:0] SEQ_LEN_4 = 3'd4;

    // Smallest code point allowed for each sequence length
    localparam logic [ACC_W-1:0] MIN_LEN_2 = 21'h00080;
    localparam logic [ACC_W-1:0] MIN_LEN_3 = 21'h00800;
    localparam logic [ACC_W-1:0] MIN_LEN_4 = 21'h10000;

    localparam logic [ACC_W-1:0] SURR_LO   = 21'h0d800;
    localparam logic [ACC_W-1:0] SURR_HI   = 21'h0dfff;
    localparam logic [ACC_W-1:0] PRINT_LO  = 21'h00020;
    localparam logic [ACC_W-1:0] DEL_CHAR  = 21'h0007f;

    localparam logic [7:0] CP437_HIGH_BASE = 8'h80;

    // Unicode value of each CP437 byte 0x80..0xff
    localparam logic [15:0] CP437_UPPER [0:127] = '{
        16'h00c7, 16'h00fc, 16'h00e9, 16'h00e2, 16'h00e4, 16'h00e0, 16'h00e5, 16'h00e7,
        16'h00ea, 16'h00eb, 16'h00e8, 16'h00ef, 16'h00ee, 16'h00ec, 16'h00c4, 16'h00c5,
        16'h00c9, 16'h00e6, 16'h00c6, 16'h00f4, 16'h00f6, 16'h00f2, 16'h00fb, 16'h00f9,
        16'h00ff, 16'h00d6, 16'h00dc, 16'h00a2, 16'h00a3, 16'h00a5, 16'h20a7, 16'h0192,
        16'h00e1, 16'h00ed, 16'h00f3, 16'h00fa, 16'h00f1, 16'h00d1, 16'h00aa, 16'h00ba,
        16'h00bf, 16'h2310, 16'h00ac, 16'h00bd, 16'h00bc, 16'h00a1, 16'h00ab, 16'h00bb,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255d, 16'h255c, 16'h255b, 16'h2510,
        16'h2514, 16'h2534, 16'h252c, 16'h251c, 16'h2500, 16'h253c, 16'h255e, 16'h255f,
        16'h255a, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256c, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256b,
        16'h256a, 16'h2518, 16'h250c, 16'h2588, 16'h2584, 16'h258c, 16'h2590, 16'h2580,
        16'h03b1, 16'h00df, 16'h0393, 16'h03c0, 16'h03a3, 16'h03c3, 16'h00b5, 16'h03c4,
        16'h03a6, 16'h0398, 16'h03a9, 16'h03b4, 16'h221e, 16'h03c6, 16'h03b5, 16'h2229,
        16'h2261, 16'h00b1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00f7, 16'h2248,
        16'h00b0, 16'h2219, 16'h00b7, 16'h221a, 16'h207f, 16'h00b2, 16'h25a0, 16'h00a0
    };

    // Outcome of one decoder step
    typedef struct packed {
        logic       emit;
        logic [7:0] cp437_byte;
        logic       byte_valid;
        logic       end_of_text;
        logic       rejected;
    } utf8cp_res_t;

endpackage

### rtl/utf8cp_map.sv
// Checks a finished code point and maps it to a CP437 byte.
module utf8cp_map (
    input  logic [utf8cp_pkg::ACC_W-1:0] code_point,
    input  logic [2:0]                   seq_len,
    output logic                         ok,
    output logic [7:0]                   cp437_byte
);
    import utf8cp_pkg::*;

    logic       len_ok;
    logic       surrogate;
    logic       control;
    logic       tbl_hit;
    logic [6:0] tbl_idx;

    always_comb
    begin
        unique case (seq_len)
            SEQ_LEN_1: len_ok = 1'b1;
            SEQ_LEN_2: len_ok = (code_point >= MIN_LEN_2);
            SEQ_LEN_3: len_ok = (code_point >= MIN_LEN_3);
            SEQ_LEN_4: len_ok = (code_point >= MIN_LEN_4);
            default:   len_ok = 1'b0;
        endcase
    end

    assign surrogate = (code_point >= SURR_LO) && (code_point <= SURR_HI);
    assign control   = (code_point < PRINT_LO) || (code_point == DEL_CHAR);

    // Reverse lookup as parallel compares; entries are unique so at most one hits
    always_comb
    begin
        tbl_hit = 1'b0;
        tbl_idx = '0;
        for (int k = 0; k < 128; k++)
        begin
            if ((code_point[ACC_W-1:16] == '0) && (code_point[15:0] == CP437_UPPER[k]))
            begin
                tbl_hit = 1'b1;
                tbl_idx = tbl_idx | 7'(k);
            end
        end
    end

    always_comb
    begin
        ok         = 1'b0;
        cp437_byte = '0;
        if (len_ok && !surrogate && !control)
        begin
            if (code_point < DEL_CHAR)
            begin
                ok         = 1'b1;
                cp437_byte = code_point[7:0];
            end
            else if (tbl_hit)
            begin
                ok         = 1'b1;
                cp437_byte = CP437_HIGH_BASE | {1'b0, tbl_idx};
            end
        end
    end

endmodule

### rtl/utf8cp_decode.sv
// UTF-8 sequence decoder: holds the partial code point and error state.
module utf8cp_decode (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              utf8_byte,
    input  logic                    last_byte,
    output utf8cp_pkg::utf8cp_res_t res
);
    import utf8cp_pkg::*;

    logic [1:0]       owed_reg, owed_next;
    logic [2:0]       len_reg, len_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             err_reg, err_next;

    logic       complete;
    logic       have_char;
    logic       map_ok;
    logic [7:0] map_byte;

    // Code point as it stands after this byte, before clearing on completion
    logic [1:0]       owed_mid;
    logic [2:0]       len_mid;
    logic [ACC_W-1:0] acc_mid;
    logic             err_mid;

    always_comb
    begin
        owed_mid = owed_reg;
        len_mid  = len_reg;
        acc_mid  = acc_reg;
        err_mid  = err_reg;
        complete = 1'b0;
        if (!err_reg)
        begin
            if (owed_reg == 2'd0)
            begin
                priority if (utf8_byte[7] == 1'b0)
                begin
                    acc_mid  = {13'd0, utf8_byte};
                    len_mid  = SEQ_LEN_1;
                    complete = 1'b1;
                end
                else if (utf8_byte[7:5] == 3'b110)
                begin
                    acc_mid  = {16'd0, utf8_byte[4:0]};
                    len_mid  = SEQ_LEN_2;
                    owed_mid = 2'd1;
                end
                else if (utf8_byte[7:4] == 4'b1110)
                begin
                    acc_mid  = {17'd0, utf8_byte[3:0]};
                    len_mid  = SEQ_LEN_3;
                    owed_mid = 2'd2;
                end
                else if (utf8_byte[7:3] == 5'b11110)
                begin
                    acc_mid  = {18'd0, utf8_byte[2:0]};
                    len_mid  = SEQ_LEN_4;
                    owed_mid = 2'd3;
                end
                else
                begin
                    err_mid = 1'b1;
                end
            end
            else if (utf8_byte[7:6] != 2'b10)
            begin
                err_mid = 1'b1;
            end
            else
            begin
                acc_mid  = {acc_reg[ACC_W-7:0], utf8_byte[5:0]};
                owed_mid = owed_reg - 2'd1;
                complete = (owed_reg == 2'd1);
            end
        end
    end

    utf8cp_map u_map (
        .code_point (acc_mid),
        .seq_len    (len_mid),
        .ok         (map_ok),
        .cp437_byte (map_byte)
    );

    assign have_char = complete && map_ok;

    always_comb
    begin
        owed_next = owed_mid;
        len_next  = len_mid;
        acc_next  = acc_mid;
        err_next  = err_mid;
        if (complete)
        begin
            err_next = err_mid | !map_ok;
            acc_next = '0;
            len_next = '0;
        end
        if (!err_reg && last_byte && (owed_mid != 2'd0))
            err_next = 1'b1;

        res.emit        = have_char || last_byte;
        res.cp437_byte  = have_char ? map_byte : 8'd0;
        res.byte_valid  = have_char;
        res.end_of_text = last_byte;
        res.rejected    = err_next;

        // End of text: back to a clean state for the next one
        if (last_byte)
        begin
            owed_next = '0;
            len_next  = '0;
            acc_next  = '0;
            err_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg <= '0;
            len_reg  <= '0;
            acc_reg  <= '0;
            err_reg  <= 1'b0;
        end
        else if (step)
        begin
            owed_reg <= owed_next;
            len_reg  <= len_next;
            acc_reg  <= acc_next;
            err_reg  <= err_next;
        end
    end

    // A text never leaves state behind it
    property p_clean_after_last;
        @(posedge clk) disable iff (!rst_n)
        (step && last_byte) |=> (owed_reg == 2'd0) && !err_reg && (acc_reg == '0);
    endproperty
    a_clean_after_last: assert property (p_clean_after_last)
        else $error("decoder state not cleared after end of text");

endmodule

### rtl/utf8_to_cp437_transcoder.sv
// Top level of the UTF-8 to CP437 transcoder: input register, decoder, result register.
//
// Takes one UTF-8 byte per item and can accept a new item every clock cycle unless the
// output stalls; a byte waits in the input register until the result register is free
// or being read, and its result is then registered there. The rate is set by the single
// decoder step that sits between the input and result registers: lead/continuation check,
// code point accumulate and the CP437 reverse lookup done as parallel compares. A result
// item is produced for each character that completes cleanly and for the last byte of a
// text (tlast); the last result carries the reject flag, and a rejected text should be
// discarded as a whole. Bytes inside a sequence and bytes after an error give no result.
// Backpressure on the output stalls the input only when both registers are full.
module utf8_to_cp437_transcoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] utf8_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] cp437_byte
    output logic [1:0] m_tuser,   // [0] byte_valid, [1] rejected
    output logic       m_tlast    // end_of_text
);
    import utf8cp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_char_reg;
    logic       out_last_reg;
    logic       out_rej_reg;

    logic        advance;
    utf8cp_res_t res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    utf8cp_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .utf8_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = res.emit;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && res.emit)
        begin
            out_byte_reg <= res.cp437_byte;
            out_char_reg <= res.byte_valid;
            out_last_reg <= res.end_of_text;
            out_rej_reg  <= res.rejected;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_rej_reg, out_char_reg};
    assign m_tlast  = out_last_reg;

    // Result without a character carries a zero byte
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0))
        else $error("result without character has non-zero byte");

    // Mid-text results only ever come from clean characters
    a_mid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser[0] && !m_tuser[1]))
        else $error("mid-text result without clean character");

    // No control character or DEL is ever passed on
    a_no_control: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0] && !m_tdata[7]) |->
            ((m_tdata >= 8'h20) && (m_tdata != 8'h7f)))
        else $error("control character emitted");

    // Input side stalls only while a held item cannot move on
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without cause");

endmodule
